>>> sv/bcpa_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths and codes for the bitmap page allocator.
package bcpa_pkg;

    localparam int OPCODE_W      = 1;
    localparam int BYTE_SIZE_W   = 32;
    localparam int START_PAGE_W  = 10;
    localparam int PAGE_COUNT_W  = 11;
    localparam int FIRST_PAGE_W  = 10;
    localparam int PAGES_TAKEN_W = 11;
    localparam int HEADER_W      = 12;

    localparam logic [HEADER_W-1:0] HEADER_RESET = 12'd12;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_SETUP,
        ST_MARK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic prep;
        logic scan;
        logic setup;
        logic mark;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_free;
        logic alloc_trivial;
        logic free_empty;
        logic found;
        logic scan_end;
        logic mark_done;
        logic slot_free;
    } status_t;

endpackage

>>> sv/bcpa_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the bitmap page allocator.
interface bcpa_req_if;
    import bcpa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OPCODE_W-1:0]      opcode;
    logic [BYTE_SIZE_W-1:0]   byte_size;
    logic [START_PAGE_W-1:0]  start_page;
    logic [PAGE_COUNT_W-1:0]  page_count;

    modport source (output valid, output opcode, output byte_size, output start_page,
                    output page_count, input ready);
    modport sink   (input valid, input opcode, input byte_size, input start_page,
                    input page_count, output ready);
endinterface

interface bcpa_rsp_if;
    import bcpa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic [FIRST_PAGE_W-1:0]  first_page;
    logic [PAGES_TAKEN_W-1:0] pages_taken;

    modport source (output valid, output ok, output first_page, output pages_taken,
                    input ready);
    modport sink   (input valid, input ok, input first_page, input pages_taken,
                    output ready);
endinterface

>>> sv/bitmap_contiguous_page_allocator_unit.sv
`timescale 1ns / 1ps
// Top level of the bitmap first-fit contiguous page allocator.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+-------------------------------------------------
//  req      | in  | valid / ready    | opcode, byte_size, start_page, page_count
//  rsp      | out | valid / ready    | ok, first_page, pages_taken
//  cfg      | in  | cfg_we           | cfg_wdata (header_bytes)
//
//  After reset a clearing pass zeroes the bitmap, one byte at a time, with req.ready low.
//  Allocate: the single bitmap read port scans one byte per cycle for a first-fit run,
//  then the run is marked with one read-modify-write per byte.
//  Free: one read-modify-write per byte spanned by the run; trivial requests skip the bitmap.
//  A finished result waits in the rsp register while the next request is taken.
module bitmap_contiguous_page_allocator_unit #(
    parameter int BITMAP_BYTES = 128,
    parameter int PAGE_BITS    = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    bcpa_req_if.sink                      req,
    bcpa_rsp_if.source                    rsp,
    input  logic                          cfg_we,
    input  logic [bcpa_pkg::HEADER_W-1:0] cfg_wdata
);
    import bcpa_pkg::*;

    localparam int TOTAL_PAGES = BITMAP_BYTES * 8;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    bcpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bcpa_dp #(
        .BITMAP_BYTES (BITMAP_BYTES),
        .PAGE_BITS    (PAGE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .opcode      (req.opcode),
        .byte_size   (req.byte_size),
        .start_page  (req.start_page),
        .page_count  (req.page_count),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .ok          (rsp.ok),
        .first_page  (rsp.first_page),
        .pages_taken (rsp.pages_taken)
    );

    assign req.ready = in_ready;

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ok |-> rsp.first_page == '0 && rsp.pages_taken == '0)
        else $error("failed response carries a non-zero run");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in flight");

    a_run_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ok |->
            (32'(rsp.first_page) + 32'(rsp.pages_taken) <= 32'(TOTAL_PAGES))
            || (TOTAL_PAGES > 1024))
        else $error("allocated run runs past the end of the bitmap");

endmodule

>>> sv/bcpa_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the bitmap page allocator.
module bcpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bcpa_pkg::status_t status,
    output bcpa_pkg::cmd_t    cmd
);
    import bcpa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (status.is_free)
                begin
                    state_next = status.free_empty ? ST_FINISH : ST_MARK;
                end
                else
                begin
                    state_next = status.alloc_trivial ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (status.found)
                begin
                    state_next = ST_SETUP;
                end
                else if (status.scan_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                if (status.mark_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:  cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PREP:   cmd.prep   = 1'b1;
            ST_SCAN:   cmd.scan   = 1'b1;
            ST_SETUP:  cmd.setup  = 1'b1;
            ST_MARK:   cmd.mark   = 1'b1;
            ST_FINISH: cmd.finish = 1'b1;
            default:   cmd        = '0;
        endcase
    end

endmodule

>>> sv/bcpa_dp.sv
`timescale 1ns / 1ps
// Datapath of the bitmap page allocator: bitmap memory, scan, marking and result registers.
module bcpa_dp #(
    parameter int BITMAP_BYTES = 128,
    parameter int PAGE_BITS    = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bcpa_pkg::cmd_t                        cmd,
    output bcpa_pkg::status_t                     status,
    input  logic                                  cfg_we,
    input  logic [bcpa_pkg::HEADER_W-1:0]         cfg_wdata,
    input  logic [bcpa_pkg::OPCODE_W-1:0]         opcode,
    input  logic [bcpa_pkg::BYTE_SIZE_W-1:0]      byte_size,
    input  logic [bcpa_pkg::START_PAGE_W-1:0]     start_page,
    input  logic [bcpa_pkg::PAGE_COUNT_W-1:0]     page_count,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic                                  ok,
    output logic [bcpa_pkg::FIRST_PAGE_W-1:0]     first_page,
    output logic [bcpa_pkg::PAGES_TAKEN_W-1:0]    pages_taken
);
    import bcpa_pkg::*;

    localparam int TOTAL_PAGES = BITMAP_BYTES * 8;
    localparam int AW  = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int PIW = AW + 3;
    localparam int PW  = $clog2(TOTAL_PAGES + 1);
    localparam int RW  = (PW > 12) ? PW : 12;
    localparam int TW  = BYTE_SIZE_W + 1;
    localparam int NW  = TW + 1 - PAGE_BITS;

    logic [7:0] mem [BITMAP_BYTES];

    logic [HEADER_W-1:0]      header_reg,     header_next;
    logic [OPCODE_W-1:0]      op_reg,         op_next;
    logic [TW-1:0]            total_reg,      total_next;
    logic [START_PAGE_W-1:0]  start_reg,      start_next;
    logic [PAGE_COUNT_W-1:0]  count_reg,      count_next;
    logic [PW-1:0]            need_reg,       need_next;
    logic [RW-1:0]            lo_reg,         lo_next;
    logic [RW-1:0]            hi_reg,         hi_next;
    logic [AW-1:0]            rd_addr_reg,    rd_addr_next;
    logic                     iss_reg,        iss_next;
    logic                     rd_vld_reg,     rd_vld_next;
    logic [AW-1:0]            rd_idx_reg,     rd_idx_next;
    logic                     rd_last_reg,    rd_last_next;
    logic [7:0]               rdata_reg;
    logic [PIW-1:0]           run_start_reg,  run_start_next;
    logic [PW-1:0]            run_len_reg,    run_len_next;
    logic [AW-1:0]            clr_addr_reg,   clr_addr_next;
    logic                     wk_ok_reg,      wk_ok_next;
    logic [FIRST_PAGE_W-1:0]  wk_first_reg,   wk_first_next;
    logic [PAGES_TAKEN_W-1:0] wk_taken_reg,   wk_taken_next;
    logic                     out_vld_reg,    out_vld_next;
    logic                     out_ok_reg,     out_ok_next;
    logic [FIRST_PAGE_W-1:0]  out_first_reg,  out_first_next;
    logic [PAGES_TAKEN_W-1:0] out_taken_reg,  out_taken_next;

    logic [NW-1:0]  need_full;
    logic           need_zero;
    logic           need_big;
    logic [RW-1:0]  free_lo;
    logic [RW-1:0]  free_sum;
    logic [RW-1:0]  free_hi;
    logic           free_empty;
    logic           issuing;
    logic           issue_last;
    logic [RW-1:0]  next_byte_page;
    logic [PW-1:0]  scan_rl;
    logic [PIW-1:0] scan_rs;
    logic           scan_found;
    logic [7:0]     mark_mask;
    logic           slot_free;
    logic           mem_we;
    logic           mem_re;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;

    // request sizing and free range
    always_comb
    begin
        need_full  = NW'(total_reg[TW-1:PAGE_BITS]) + NW'(|total_reg[PAGE_BITS-1:0]);
        need_zero  = (need_full == '0);
        need_big   = (need_full > NW'(TOTAL_PAGES));
        free_lo    = RW'(start_reg);
        free_sum   = RW'(start_reg) + RW'(count_reg);
        free_hi    = (free_sum > RW'(TOTAL_PAGES)) ? RW'(TOTAL_PAGES) : free_sum;
        free_empty = (free_lo >= free_hi);
    end

    // read issue control
    always_comb
    begin
        issuing        = (cmd.scan || cmd.mark) && iss_reg;
        next_byte_page = RW'({({1'b0, rd_addr_reg} + 1'b1), 3'b000});
        if (cmd.scan)
        begin
            issue_last = (rd_addr_reg == AW'(BITMAP_BYTES - 1));
        end
        else
        begin
            issue_last = (next_byte_page >= hi_reg);
        end
    end

    // first-fit run tracking over one byte
    always_comb
    begin
        logic [PW-1:0]  rl;
        logic [PIW-1:0] rs;
        logic           f;
        rl = run_len_reg;
        rs = run_start_reg;
        f  = 1'b0;
        for (int j = 0; j < 8; j++)
        begin
            if (!f)
            begin
                if (rdata_reg[7-j])
                begin
                    rl = '0;
                end
                else
                begin
                    if (rl == '0)
                    begin
                        rs = {rd_idx_reg, 3'(j)};
                    end
                    rl = rl + 1'b1;
                    if (rl == need_reg)
                    begin
                        f = 1'b1;
                    end
                end
            end
        end
        scan_rl    = rl;
        scan_rs    = rs;
        scan_found = f;
    end

    // page range mask for the byte being modified
    always_comb
    begin
        logic [RW-1:0] pg;
        for (int j = 0; j < 8; j++)
        begin
            pg             = RW'({rd_idx_reg, 3'(j)});
            mark_mask[7-j] = (pg >= lo_reg) && (pg < hi_reg);
        end
    end

    assign slot_free = !out_vld_reg || out_ready;

    always_comb
    begin
        mem_re    = issuing;
        mem_we    = cmd.clear_step || (cmd.mark && rd_vld_reg);
        mem_waddr = cmd.clear_step ? clr_addr_reg : rd_idx_reg;
        if (cmd.clear_step)
        begin
            mem_wdata = '0;
        end
        else if (op_reg == OP_ALLOC)
        begin
            mem_wdata = rdata_reg | mark_mask;
        end
        else
        begin
            mem_wdata = rdata_reg & ~mark_mask;
        end
    end

    always_comb
    begin
        header_next    = header_reg;
        op_next        = op_reg;
        total_next     = total_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        need_next      = need_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        rd_addr_next   = rd_addr_reg;
        iss_next       = iss_reg;
        rd_vld_next    = issuing;
        rd_idx_next    = rd_idx_reg;
        rd_last_next   = rd_last_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        clr_addr_next  = clr_addr_reg;
        wk_ok_next     = wk_ok_reg;
        wk_first_next  = wk_first_reg;
        wk_taken_next  = wk_taken_reg;
        out_vld_next   = out_vld_reg;
        out_ok_next    = out_ok_reg;
        out_first_next = out_first_reg;
        out_taken_next = out_taken_reg;

        if (cfg_we)
        begin
            header_next = cfg_wdata;
        end

        if (cmd.clear_step)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end

        if (cmd.load)
        begin
            op_next    = opcode;
            total_next = TW'(byte_size) + TW'(header_reg);
            start_next = start_page;
            count_next = page_count;
        end

        if (cmd.prep)
        begin
            need_next     = need_full[PW-1:0];
            run_len_next  = '0;
            wk_ok_next    = (op_reg == OP_FREE) || need_zero;
            wk_first_next = '0;
            wk_taken_next = '0;
            if (op_reg == OP_FREE)
            begin
                lo_next      = free_lo;
                hi_next      = free_hi;
                rd_addr_next = free_lo[AW+2:3];
                iss_next     = !free_empty;
            end
            else
            begin
                rd_addr_next = '0;
                iss_next     = 1'b1;
            end
        end

        if (issuing)
        begin
            rd_idx_next  = rd_addr_reg;
            rd_last_next = issue_last;
            if (issue_last)
            begin
                iss_next = 1'b0;
            end
            else
            begin
                rd_addr_next = rd_addr_reg + 1'b1;
            end
        end

        if (cmd.scan && rd_vld_reg)
        begin
            run_start_next = scan_rs;
            run_len_next   = scan_rl;
        end

        if (cmd.setup)
        begin
            lo_next       = RW'(run_start_reg);
            hi_next       = RW'(run_start_reg) + RW'(need_reg);
            rd_addr_next  = run_start_reg[PIW-1:3];
            iss_next      = 1'b1;
            wk_ok_next    = 1'b1;
            wk_first_next = FIRST_PAGE_W'(run_start_reg);
            wk_taken_next = PAGES_TAKEN_W'(need_reg);
        end

        if (cmd.finish && slot_free)
        begin
            out_vld_next   = 1'b1;
            out_ok_next    = wk_ok_reg;
            out_first_next = wk_first_reg;
            out_taken_next = wk_taken_reg;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= HEADER_RESET;
            iss_reg      <= 1'b0;
            rd_vld_reg   <= 1'b0;
            clr_addr_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            header_reg   <= header_next;
            iss_reg      <= iss_next;
            rd_vld_reg   <= rd_vld_next;
            clr_addr_reg <= clr_addr_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        total_reg     <= total_next;
        start_reg     <= start_next;
        count_reg     <= count_next;
        need_reg      <= need_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        rd_addr_reg   <= rd_addr_next;
        rd_idx_reg    <= rd_idx_next;
        rd_last_reg   <= rd_last_next;
        run_start_reg <= run_start_next;
        run_len_reg   <= run_len_next;
        wk_ok_reg     <= wk_ok_next;
        wk_first_reg  <= wk_first_next;
        wk_taken_reg  <= wk_taken_next;
        out_ok_reg    <= out_ok_next;
        out_first_reg <= out_first_next;
        out_taken_reg <= out_taken_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    always_comb
    begin
        status.clear_last    = (clr_addr_reg == AW'(BITMAP_BYTES - 1));
        status.is_free       = (op_reg == OP_FREE);
        status.alloc_trivial = need_zero || need_big;
        status.free_empty    = free_empty;
        status.found         = rd_vld_reg && scan_found;
        status.scan_end      = rd_vld_reg && rd_last_reg && !scan_found;
        status.mark_done     = rd_vld_reg && rd_last_reg;
        status.slot_free     = slot_free;
    end

    assign out_valid   = out_vld_reg;
    assign ok          = out_ok_reg;
    assign first_page  = out_first_reg;
    assign pages_taken = out_taken_reg;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the bitmap first-fit page allocator: directed and random traffic.
module testbench;
    import bcpa_pkg::*;

    localparam int BITMAP_BYTES  = 128;
    localparam int PAGE_BITS     = 12;
    localparam int TOTAL_PAGES   = BITMAP_BYTES * 8;
    localparam int PAGE_BYTES    = 1 << PAGE_BITS;
    localparam int SETTLE_CYCLES = 2 * BITMAP_BYTES + 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 117;

    typedef struct packed {
        logic                     ok;
        logic [FIRST_PAGE_W-1:0]  first_page;
        logic [PAGES_TAKEN_W-1:0] pages_taken;
    } outcome_t;

    typedef struct {
        int unsigned start;
        int unsigned count;
    } run_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [HEADER_W-1:0] cfg_wdata;

    bcpa_req_if req_bus ();
    bcpa_rsp_if rsp_bus ();

    logic [7:0]          page_map [0:BITMAP_BYTES-1];
    logic [HEADER_W-1:0] header_model;
    outcome_t            pending_outcomes [$];
    run_t                live_runs [$];
    int                  mismatch_count = 0;
    int                  stalled_cycles = 0;
    bit                  quiet_mode = 1'b0;

    bitmap_contiguous_page_allocator_unit #(
        .BITMAP_BYTES(BITMAP_BYTES),
        .PAGE_BITS   (PAGE_BITS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_bus),
        .rsp      (rsp_bus),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic page_used(input int unsigned p);
        return page_map[p >> 3][7 - (p & 7)];
    endfunction

    function automatic void set_page(input int unsigned p, input logic used);
        page_map[p >> 3][7 - (p & 7)] = used;
    endfunction

    function automatic outcome_t first_fit_alloc(input logic [BYTE_SIZE_W-1:0] size);
        logic [33:0] need_wide;
        int unsigned need;
        int unsigned run_start;
        int unsigned run_len;
        bit          found;
        outcome_t    res;
        res       = '0;
        run_start = 0;
        run_len   = 0;
        found     = 1'b0;
        need_wide = ({2'b00, size} + {22'd0, header_model} + 34'(PAGE_BYTES - 1)) >> PAGE_BITS;
        if (need_wide == 0)
        begin
            res.ok = 1'b1;
            return res;
        end
        if (need_wide > TOTAL_PAGES)
            return res;
        need = int'(need_wide);
        for (int unsigned p = 0; p < TOTAL_PAGES; p++)
        begin
            if (page_used(p))
                run_len = 0;
            else
            begin
                if (run_len == 0)
                    run_start = p;
                run_len++;
                if (run_len == need)
                begin
                    found = 1'b1;
                    break;
                end
            end
        end
        if (!found)
            return res;
        for (int unsigned k = 0; k < run_len; k++)
            set_page(run_start + k, 1'b1);
        res.ok          = 1'b1;
        res.first_page  = run_start[FIRST_PAGE_W-1:0];
        res.pages_taken = run_len[PAGES_TAKEN_W-1:0];
        live_runs.push_back('{run_start, run_len});
        return res;
    endfunction

    function automatic outcome_t release_pages(input int unsigned start, input int unsigned count);
        outcome_t res;
        for (int unsigned k = 0; k < count; k++)
        begin
            if (start + k >= TOTAL_PAGES)
                break;
            set_page(start + k, 1'b0);
        end
        res    = '0;
        res.ok = 1'b1;
        return res;
    endfunction

    // Leave valid high after the transfer; the next call drops it before a random gap, wait_for_outcomes drops it.
    task automatic send_request(input logic [OPCODE_W-1:0] opcode,
                                input logic [BYTE_SIZE_W-1:0] byte_size,
                                input logic [START_PAGE_W-1:0] start_page,
                                input logic [PAGE_COUNT_W-1:0] page_count);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.opcode     <= opcode;
        req_bus.byte_size  <= byte_size;
        req_bus.start_page <= start_page;
        req_bus.page_count <= page_count;
        do @(posedge clk); while (!req_bus.ready);
        if (opcode == OP_FREE)
            pending_outcomes.push_back(release_pages(start_page, page_count));
        else
            pending_outcomes.push_back(first_fit_alloc(byte_size));
    endtask

    task automatic alloc_request(input logic [BYTE_SIZE_W-1:0] byte_size);
        send_request(OP_ALLOC, byte_size, START_PAGE_W'($urandom_range(0, 1023)),
                     PAGE_COUNT_W'($urandom_range(0, 1024)));
    endtask

    task automatic free_request(input int unsigned start, input int unsigned count);
        send_request(OP_FREE, $urandom, start[START_PAGE_W-1:0], count[PAGE_COUNT_W-1:0]);
    endtask

    task automatic wait_for_outcomes();
        req_bus.valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_header(input logic [HEADER_W-1:0] value);
        wait_for_outcomes();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        header_model = value;
    endtask

    task automatic test_header_rounding();
        alloc_request(32'd0);
        alloc_request(32'd4084);
        alloc_request(32'd4085);
        free_request(0, 4);
    endtask

    task automatic test_zero_page();
        write_header(12'd0);
        alloc_request(32'd0);
        alloc_request(32'd1);
        free_request(0, 1);
    endtask

    task automatic test_exhaustion();
        alloc_request(32'(TOTAL_PAGES * PAGE_BYTES));
        alloc_request(32'd1);
        free_request(1000, 1024);
        alloc_request(32'(24 * PAGE_BYTES));
        alloc_request(32'((TOTAL_PAGES + 1) * PAGE_BYTES));
        free_request(0, 1024);
    endtask

    task automatic test_first_fit();
        alloc_request(32'(3 * PAGE_BYTES));
        alloc_request(32'(5 * PAGE_BYTES));
        alloc_request(32'(2 * PAGE_BYTES));
        free_request(3, 5);
        alloc_request(32'(6 * PAGE_BYTES));
        alloc_request(32'(4 * PAGE_BYTES));
        free_request(3, 3);
        free_request(0, 1024);
    endtask

    task automatic test_field_extremes();
        write_header(12'hFFF);
        alloc_request(32'hFFFF_FFFF);
        alloc_request(32'd1);
        free_request(1023, 1024);
        free_request(0, 0);
    endtask

    task automatic test_random_traffic();
        logic [HEADER_W-1:0] header;
        int                  pick;
        int                  slot;
        logic [31:0]         size;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                1:       header = '0;
                2:       header = '1;
                3:       header = HEADER_RESET;
                default: header = HEADER_W'($urandom_range(0, 4095));
            endcase
            write_header(header);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                    quiet_mode = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 70)
                        size = $urandom_range(0, 16 * PAGE_BYTES);
                    else if (pick < 85)
                        size = $urandom_range(0, 256 * PAGE_BYTES);
                    else if (pick < 90)
                        size = $urandom_range((TOTAL_PAGES - 4) * PAGE_BYTES,
                                              (TOTAL_PAGES + 1) * PAGE_BYTES);
                    else
                        size = $urandom;
                    alloc_request(size);
                end
                else if (pick < 85 && live_runs.size() != 0)
                begin
                    slot = $urandom_range(0, live_runs.size() - 1);
                    free_request(live_runs[slot].start, live_runs[slot].count);
                    live_runs.delete(slot);
                end
                else if ($urandom_range(0, 4) != 0)
                    free_request($urandom_range(0, 1023), $urandom_range(0, 64));
                else
                    free_request($urandom_range(0, 1023), $urandom_range(0, 1024));
            end
        end
        quiet_mode = 1'b0;
    endtask

    initial
    begin : rsp_ready_driver
        int stall;
        rsp_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = quiet_mode ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                if ($urandom_range(0, 1) == 1)
                    do @(posedge clk); while (!rsp_bus.valid);
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (!rsp_bus.valid);
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected transfer, expected none, %s %0d first %0d taken %0d",
                         $time, "actual ok", rsp_bus.ok, rsp_bus.first_page,
                         rsp_bus.pages_taken);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (rsp_bus.ok !== want.ok)
                begin
                    mismatch_count++;
                    $display("%0t: ok expected %0d actual %0d", $time, want.ok, rsp_bus.ok);
                end
                if (rsp_bus.first_page !== want.first_page)
                begin
                    mismatch_count++;
                    $display("%0t: first_page expected %0d actual %0d",
                             $time, want.first_page, rsp_bus.first_page);
                end
                if (rsp_bus.pages_taken !== want.pages_taken)
                begin
                    mismatch_count++;
                    $display("%0t: pages_taken expected %0d actual %0d",
                             $time, want.pages_taken, rsp_bus.pages_taken);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, stalled_cycles, pending_outcomes.size());
                $display("bitmap_contiguous_page_allocator_unit verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.opcode     <= OP_ALLOC;
        req_bus.byte_size  <= '0;
        req_bus.start_page <= '0;
        req_bus.page_count <= '0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        header_model = HEADER_RESET;
        for (int b = 0; b < BITMAP_BYTES; b++)
            page_map[b] = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_header_rounding();
        test_zero_page();
        test_exhaustion();
        test_first_fit();
        test_field_extremes();
        test_random_traffic();

        wait_for_outcomes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("bitmap_contiguous_page_allocator_unit verification clean");
        else
            $display("bitmap_contiguous_page_allocator_unit verification failed");
        $finish;
    end

endmodule
